[hw/rtl/letterbox_fit_layout_assert.svh]
// Assertion macros used by the letterbox fit layout output stage.
`ifndef LETTERBOX_FIT_LAYOUT_ASSERT_SVH
`define LETTERBOX_FIT_LAYOUT_ASSERT_SVH

// Checked outside reset only.
`define LBF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("letterbox fit layout check failed");

// Checked at every edge, reset included.
`define LBF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("letterbox fit layout check failed");

`endif

[hw/rtl/lbfit_pkg.sv]
// Types and constants shared by the letterbox fit layout modules.
`timescale 1ns / 1ps
package lbfit_pkg;

   localparam int DIM_W  = 13;
   localparam int PROD_W = 2 * DIM_W;
   localparam int COORD_W = 16;
   localparam int PLACE_W = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MAX_DIMENSION_DEF = 8191;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOUND_X      = 3'd0,
      CSR_BOUND_Y      = 3'd1,
      CSR_BOUND_WIDTH  = 3'd2,
      CSR_BOUND_HEIGHT = 3'd3,
      CSR_STRETCH      = 3'd4,
      CSR_KEEP_ASPECT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_CENTER = 2'd0,
      MODE_FILL   = 2'd1,
      MODE_FIT_W  = 2'd2,
      MODE_FIT_H  = 2'd3
   } mode_type;

   typedef struct packed {
      logic                zero;
      mode_type            mode;
      logic [DIM_W-1:0]    iw;
      logic [DIM_W-1:0]    ih;
      logic [DIM_W-1:0]    bw;
      logic [DIM_W-1:0]    bh;
      logic [COORD_W-1:0]  bx;
      logic [COORD_W-1:0]  by;
      logic [PROD_W-1:0]   dividend;
      logic [DIM_W-1:0]    divisor;
      logic [DIM_W-1:0]    rem;
      logic [DIM_W-1:0]    quot;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0] bound_x;
      logic [COORD_W-1:0] bound_y;
      logic [DIM_W-1:0]   area_width;
      logic [DIM_W-1:0]   area_height;
      logic               stretch_enable;
      logic               keep_aspect;
   } cfg_type;

endpackage

[hw/rtl/letterbox_fit_layout.sv]
// Pipeline: two front stages, thirteen divider cells and one output register
// lie between input transfer and result.
// Throughput: one item per cycle while the receiver takes results; the chain of
// divider cells, one quotient bit per cell, sets this figure and each stage stalls only when full.
// Reset (synchronous) empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
module letterbox_fit_layout #(
   parameter int MAX_DIMENSION = lbfit_pkg::MAX_DIMENSION_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // source_width [12:0], source_height [25:13], zero fill [31:26]
   input  logic [31:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // place_x, place_y, place_width, place_height, pad_left, pad_top,
   // pad_right, pad_bottom
   output logic [111:0]                     rsp_tdata,
   // valid_res
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [lbfit_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbfit_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lbfit_pkg::*;

   cfg_type  cfg_ff;
   logic     chain_valid [0:DIM_W];
   logic     chain_ready [0:DIM_W];
   item_type chain_item  [0:DIM_W];
   logic [PLACE_W-1:0] px, py;
   logic [DIM_W-1:0]   pw, ph, pl, pt, pr, pb;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bound_x        <= '0;
         cfg_ff.bound_y        <= '0;
         cfg_ff.area_width     <= DIM_W'(1920);
         cfg_ff.area_height    <= DIM_W'(1080);
         cfg_ff.stretch_enable <= 1'b0;
         cfg_ff.keep_aspect    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOUND_X:      cfg_ff.bound_x        <= csr_wdata;
            CSR_BOUND_Y:      cfg_ff.bound_y        <= csr_wdata;
            CSR_BOUND_WIDTH:  cfg_ff.area_width     <= csr_wdata[DIM_W-1:0];
            CSR_BOUND_HEIGHT: cfg_ff.area_height    <= csr_wdata[DIM_W-1:0];
            CSR_STRETCH:      cfg_ff.stretch_enable <= csr_wdata[0];
            CSR_KEEP_ASPECT:  cfg_ff.keep_aspect    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   lbfit_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_iw     (req_tdata[DIM_W-1:0]),
      .in_ih     (req_tdata[2*DIM_W-1:DIM_W]),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_item  (chain_item[0])
   );

   for (genvar g = 0; g < DIM_W; g++) begin : g_cell
      lbfit_div_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   lbfit_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[DIM_W]),
      .in_ready     (chain_ready[DIM_W]),
      .in_item      (chain_item[DIM_W]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .place_x      (px),
      .place_y      (py),
      .place_width  (pw),
      .place_height (ph),
      .pad_left     (pl),
      .pad_top      (pt),
      .pad_right    (pr),
      .pad_bottom   (pb),
      .valid_res    (rsp_tuser)
   );

   assign rsp_tdata = {pb, pr, pt, pl, ph, pw, py, px};

endmodule

[hw/rtl/lbfit_front.sv]
// Input stages: clamping, cross products and choice of placement mode.
`timescale 1ns / 1ps
module lbfit_front #(
   parameter int MAX_DIMENSION = lbfit_pkg::MAX_DIMENSION_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lbfit_pkg::cfg_type          cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [lbfit_pkg::DIM_W-1:0] in_iw,
   input  logic [lbfit_pkg::DIM_W-1:0] in_ih,
   output logic                        out_valid,
   input  logic                        out_ready,
   output lbfit_pkg::item_type         out_item
);
   import lbfit_pkg::*;

   localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIMENSION);

   logic              a_valid_ff, a_valid_in;
   logic              a_zero_ff, a_st_ff, a_ka_ff;
   logic [DIM_W-1:0]  a_iw_ff, a_ih_ff, a_bw_ff, a_bh_ff;
   logic [COORD_W-1:0] a_bx_ff, a_by_ff;
   logic [PROD_W-1:0] a_wprod_ff, a_hprod_ff;
   logic              b_valid_ff, b_valid_in;
   item_type          b_item_ff, b_item_in;
   logic [DIM_W-1:0]  iw_c, ih_c, bw_c, bh_c;
   logic              a_adv, b_adv, fits_bound, wider;

   function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v);
      return (32'(v) > 32'(MAX_DIMENSION)) ? MAX_D : v;
   endfunction

   assign b_adv    = !b_valid_ff || out_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;
   assign iw_c = clamp(in_iw);
   assign ih_c = clamp(in_ih);
   assign bw_c = clamp(cfg.area_width);
   assign bh_c = clamp(cfg.area_height);
   assign a_valid_in = a_adv ? in_valid : a_valid_ff;
   assign b_valid_in = b_adv ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_zero_ff  <= (iw_c == '0) || (ih_c == '0);
         a_iw_ff    <= iw_c;
         a_ih_ff    <= ih_c;
         a_bw_ff    <= bw_c;
         a_bh_ff    <= bh_c;
         a_bx_ff    <= cfg.bound_x;
         a_by_ff    <= cfg.bound_y;
         a_st_ff    <= cfg.stretch_enable;
         a_ka_ff    <= cfg.keep_aspect;
         a_wprod_ff <= PROD_W'(iw_c) * PROD_W'(bh_c);
         a_hprod_ff <= PROD_W'(bw_c) * PROD_W'(ih_c);
      end
      if (b_adv) begin
         b_item_ff <= b_item_in;
      end
   end

   always_comb begin
      fits_bound = (a_iw_ff <= a_bw_ff) && (a_ih_ff <= a_bh_ff);
      wider  = a_wprod_ff >= a_hprod_ff;
      b_item_in = '0;
      b_item_in.zero = a_zero_ff;
      b_item_in.iw = a_iw_ff;
      b_item_in.ih = a_ih_ff;
      b_item_in.bw = a_bw_ff;
      b_item_in.bh = a_bh_ff;
      b_item_in.bx = a_bx_ff;
      b_item_in.by = a_by_ff;
      if (fits_bound && !a_st_ff) begin
         b_item_in.mode = MODE_CENTER;
      end else if (!a_ka_ff) begin
         b_item_in.mode = MODE_FILL;
      end else if (wider) begin
         b_item_in.mode = MODE_FIT_W;
      end else begin
         b_item_in.mode = MODE_FIT_H;
      end
      if (wider) begin
         b_item_in.dividend = a_hprod_ff;
         b_item_in.divisor  = a_iw_ff;
      end else begin
         b_item_in.dividend = a_wprod_ff;
         b_item_in.divisor  = a_ih_ff;
      end
      b_item_in.rem  = b_item_in.dividend[PROD_W-1:DIM_W];
      b_item_in.quot = '0;
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

[hw/rtl/lbfit_div_cell.sv]
// One cell of the divider chain: forms one quotient bit per transfer.
`timescale 1ns / 1ps
module lbfit_div_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  lbfit_pkg::item_type in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output lbfit_pkg::item_type out_item
);
   import lbfit_pkg::*;

   localparam int BIT = DIM_W - 1 - STEP;

   logic           valid_ff, valid_in, adv, ge;
   item_type       item_ff, item_in;
   logic [DIM_W:0] trial, diff;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;
   assign valid_in = adv ? in_valid : valid_ff;

   always_comb begin
      trial = {in_item.rem, in_item.dividend[BIT]};
      diff  = trial - {1'b0, in_item.divisor};
      ge    = trial >= {1'b0, in_item.divisor};
      item_in = in_item;
      item_in.rem  = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      item_in.quot = {in_item.quot[DIM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[hw/rtl/lbfit_back.sv]
// Output stage: placed rectangle, paddings and result register.
`timescale 1ns / 1ps
module lbfit_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  lbfit_pkg::item_type           in_item,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [lbfit_pkg::PLACE_W-1:0] place_x,
   output logic [lbfit_pkg::PLACE_W-1:0] place_y,
   output logic [lbfit_pkg::DIM_W-1:0]   place_width,
   output logic [lbfit_pkg::DIM_W-1:0]   place_height,
   output logic [lbfit_pkg::DIM_W-1:0]   pad_left,
   output logic [lbfit_pkg::DIM_W-1:0]   pad_top,
   output logic [lbfit_pkg::DIM_W-1:0]   pad_right,
   output logic [lbfit_pkg::DIM_W-1:0]   pad_bottom,
   output logic                          valid_res
);
   import lbfit_pkg::*;
   `include "letterbox_fit_layout_assert.svh"

   logic               valid_ff, valid_in, adv;
   logic [DIM_W-1:0]   pw, ph, pl, pt, pw_ff, ph_ff, pl_ff, pt_ff, pr_ff, pb_ff;
   logic [PLACE_W-1:0] px_ff, py_ff;
   logic               res_ff;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;
   assign valid_in = adv ? in_valid : valid_ff;

   always_comb begin
      pw = in_item.bw;
      ph = in_item.bh;
      pl = '0;
      pt = '0;
      unique case (in_item.mode)
         MODE_CENTER: begin
            pw = in_item.iw;
            ph = in_item.ih;
            pl = DIM_W'(in_item.bw - in_item.iw) >> 1;
            pt = DIM_W'(in_item.bh - in_item.ih) >> 1;
         end
         MODE_FILL: begin
         end
         MODE_FIT_W: begin
            ph = in_item.quot;
            pt = DIM_W'(in_item.bh - in_item.quot) >> 1;
         end
         MODE_FIT_H: begin
            pw = in_item.quot;
            pl = DIM_W'(in_item.bw - in_item.quot) >> 1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (in_item.zero) begin
            px_ff  <= '0;
            py_ff  <= '0;
            pw_ff  <= '0;
            ph_ff  <= '0;
            pl_ff  <= '0;
            pt_ff  <= '0;
            pr_ff  <= '0;
            pb_ff  <= '0;
            res_ff <= 1'b0;
         end else begin
            px_ff  <= PLACE_W'(signed'(in_item.bx)) + PLACE_W'(pl);
            py_ff  <= PLACE_W'(signed'(in_item.by)) + PLACE_W'(pt);
            pw_ff  <= pw;
            ph_ff  <= ph;
            pl_ff  <= pl;
            pt_ff  <= pt;
            pr_ff  <= in_item.bw - pl - pw;
            pb_ff  <= in_item.bh - pt - ph;
            res_ff <= 1'b1;
         end
      end
   end

   assign out_valid    = valid_ff;
   assign place_x      = px_ff;
   assign place_y      = py_ff;
   assign place_width  = pw_ff;
   assign place_height = ph_ff;
   assign pad_left     = pl_ff;
   assign pad_top      = pt_ff;
   assign pad_right    = pr_ff;
   assign pad_bottom   = pb_ff;
   assign valid_res    = res_ff;

   `LBF_ASSERT(a_fitw_quot, clock, reset, in_valid && !in_item.zero && in_item.mode == MODE_FIT_W |-> in_item.quot <= in_item.bh)
   `LBF_ASSERT(a_fith_quot, clock, reset, in_valid && !in_item.zero && in_item.mode == MODE_FIT_H |-> in_item.quot <= in_item.bw)
   `LBF_ASSERT(a_zero_out, clock, reset, out_valid && !valid_res |-> place_width == '0 && pad_right == '0 && place_x == '0)
   `LBF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !out_valid)

endmodule

[verif/tb.sv]
// Self-checking testbench for the letterbox fit layout block.
`timescale 1ns / 1ps
module tb;
   import lbfit_pkg::*;

   typedef struct packed {
      logic [12:0] pad_bottom;
      logic [12:0] pad_right;
      logic [12:0] pad_top;
      logic [12:0] pad_left;
      logic [12:0] place_height;
      logic [12:0] place_width;
      logic [16:0] place_y;
      logic [16:0] place_x;
   } layout_type;

   typedef struct {
      layout_type lay;
      logic       ok;
   } placement_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [111:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BOUND_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic signed [15:0] bx, by;
   logic [12:0] bw, bh;
   logic stretch, keep;

   placement_type pending_q[$];
   int errors = 0;
   int hold_off = 0;
   bit sender_done = 0;

   letterbox_fit_layout u_top (.*);

   always #4 clock = ~clock;

   function automatic placement_type place_source(logic [12:0] iw, logic [12:0] ih);
      placement_type r;
      logic [31:0] pw, ph, pl, pt;
      logic signed [31:0] px, py;
      r.lay = '0;
      r.ok = 0;
      if (iw == 0 || ih == 0) return r;
      if (iw <= bw && ih <= bh && !stretch) begin
         pw = 32'(iw); ph = 32'(ih);
         pl = (32'(bw) - 32'(iw)) / 2; pt = (32'(bh) - 32'(ih)) / 2;
      end else if (!keep) begin
         pw = 32'(bw); ph = 32'(bh); pl = 0; pt = 0;
      end else if (64'(iw) * bh >= 64'(bw) * ih) begin
         pw = 32'(bw); ph = 32'((64'(ih) * bw) / iw); pl = 0; pt = (32'(bh) - ph) / 2;
      end else begin
         ph = 32'(bh); pw = 32'((64'(iw) * bh) / ih); pt = 0; pl = (32'(bw) - pw) / 2;
      end
      px = 32'(bx) + $signed(pl);
      py = 32'(by) + $signed(pt);
      r.lay.place_x = px[16:0];
      r.lay.place_y = py[16:0];
      r.lay.place_width = pw[12:0];
      r.lay.place_height = ph[12:0];
      r.lay.pad_left = pl[12:0];
      r.lay.pad_top = pt[12:0];
      r.lay.pad_right = 13'(32'(bw) - pl - pw);
      r.lay.pad_bottom = 13'(32'(bh) - pt - ph);
      r.ok = 1;
      return r;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_BOUND_X: bx = val;
         CSR_BOUND_Y: by = val;
         CSR_BOUND_WIDTH: bw = val[12:0];
         CSR_BOUND_HEIGHT: bh = val[12:0];
         CSR_STRETCH: stretch = val[0];
         default: keep = val[0];
      endcase
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic send_size(logic [12:0] iw, logic [12:0] ih, bit gaps,
                            bit typed, placement_type want);
      placement_type p;
      int gap;
      if (gaps) gap = $urandom_range(0, 17);
      else gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      p = place_source(iw, ih);
      if (typed && (p.lay != want.lay || p.ok != want.ok))
         $display("%0t: table row %0d x %0d disagrees with predictor", $time, iw, ih);
      req_tvalid <= 1;
      req_tdata <= {6'd0, ih, iw};
      pending_q.push_back(typed ? want : p);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic set_layout(logic [15:0] x, logic [15:0] y, logic [12:0] w,
                             logic [12:0] h, bit s, bit k);
      write_reg(CSR_BOUND_X, x);
      write_reg(CSR_BOUND_Y, y);
      write_reg(CSR_BOUND_WIDTH, {3'd0, w});
      write_reg(CSR_BOUND_HEIGHT, {3'd0, h});
      write_reg(CSR_STRETCH, {15'd0, s});
      write_reg(CSR_KEEP_ASPECT, {15'd0, k});
   endtask

   function automatic logic [12:0] rand_dim(logic [12:0] lim);
      case ($urandom_range(0, 5))
         0: return 13'($urandom_range(0, 8191));
         1: return 13'($urandom_range(0, 3));
         2: return lim;
         default: return 13'($urandom_range(1, lim == 0 ? 1 : 32'(lim) * 2));
      endcase
   endfunction

   typedef struct {
      logic [12:0] iw, ih;
      bit typed;
      layout_type lay;
      logic ok;
   } row_type;

   row_type rows[$];

   initial begin
      placement_type w;
      bx = 0; by = 0; bw = 1920; bh = 1080; stretch = 0; keep = 1;
      repeat (8) @(posedge clock);
      reset <= 0;
      // Reset defaults: zero dimension, equal to bound, centred, extremes.
      rows.push_back('{13'd0, 13'd100, 1, '0, 0});
      rows.push_back('{13'd100, 13'd0, 1, '0, 0});
      rows.push_back('{13'd0, 13'd0, 1, '0, 0});
      rows.push_back('{13'd1920, 13'd1080, 1,
                       '{13'd0, 13'd0, 13'd0, 13'd0, 13'd1080, 13'd1920, 17'd0, 17'd0}, 1});
      rows.push_back('{13'd1920, 13'd1000, 1,
                       '{13'd40, 13'd0, 13'd40, 13'd0, 13'd1000, 13'd1920, 17'd40, 17'd0}, 1});
      rows.push_back('{13'd1, 13'd1, 0, '0, 0});
      rows.push_back('{13'd8191, 13'd8191, 0, '0, 0});
      rows.push_back('{13'd8191, 13'd1, 0, '0, 0});
      rows.push_back('{13'd1, 13'd8191, 0, '0, 0});
      rows.push_back('{13'd3841, 13'd2160, 0, '0, 0});
      rows.push_back('{13'd1921, 13'd1081, 0, '0, 0});
      rows.push_back('{13'd5461, 13'd2730, 0, '0, 0});
      foreach (rows[i]) begin
         w.lay = rows[i].lay; w.ok = rows[i].ok;
         send_size(rows[i].iw, rows[i].ih, 0, rows[i].typed, w);
      end
      drain();
      set_layout(16'h8000, 16'h7FFF, 13'd8191, 13'd8191, 1, 1);
      foreach (rows[i]) send_size(rows[i].iw, rows[i].ih, 1, 0, w);
      drain();
      set_layout(16'h7FFF, 16'h8000, 13'd1, 13'd1, 0, 0);
      foreach (rows[i]) send_size(rows[i].iw, rows[i].ih, 0, 0, w);
      drain();
      set_layout(16'h1234, 16'hFEDC, 13'd0, 13'd480, 1, 0);
      foreach (rows[i]) send_size(rows[i].iw, rows[i].ih, 0, 0, w);
      drain();
      // Long receiver hold-off while the sender keeps offering transfers.
      set_layout(16'h0000, 16'h0000, 13'd1920, 13'd1080, 0, 1);
      hold_off = 300;
      repeat (60) send_size(rand_dim(bw), rand_dim(bh), 0, 0, w);
      for (int ph = 0; ph < 10; ph++) begin
         drain();
         set_layout(16'($urandom), 16'($urandom), ph == 9 ? 13'd1 : rand_dim(13'd4000),
                    ph == 8 ? 13'd8191 : 13'($urandom_range(1, 8191)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         for (int n = 0; n < 48; n++)
            send_size(rand_dim(bw), rand_dim(bh), (ph % 3) != 0, 0, w);
      end
      drain();
      sender_done = 1;
   end

   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if ($urandom_range(0, 1)) wait_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_tready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      placement_type e;
      layout_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h / %b", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            e = pending_q.pop_front();
            if (got != e.lay || rsp_tuser != e.ok) begin
               $display("%0t: mismatch expected %h / %b actual %h / %b",
                        $time, e.lay, e.ok, got, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (sender_done);
      if (pending_q.size() != 0) errors++;
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
